### rtl/core/cugw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cugw_pkg;
  localparam int unsigned AddrW  = 30;
  localparam int unsigned CntW   = 6;
  localparam int unsigned OrbW   = 5;
  // binomial weights up to C(32,16) fit in 30 bits, the walk weight needs one more
  localparam int unsigned BinW   = 30;
  localparam int unsigned WgtW   = 31;
  localparam int unsigned MaxRes = 32;
  localparam int unsigned MaxOrb = 32;
  localparam int unsigned WopW   = 3;

  typedef enum logic {
    RegOrbitals  = 1'b0,
    RegElectrons = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    StIdle,
    StSetup,
    StCheck,
    StWalk,
    StEmit
  } state_e;

  // operations of a weight cell
  typedef enum logic [WopW-1:0] {
    WHold,
    WSeed,
    WUp,
    WDown,
    WAdd,
    WSub
  } wop_e;
endpackage
`default_nettype wire

### rtl/core/cugw_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface cugw_in_if;
  logic valid;
  logic ready;
  logic [cugw_pkg::AddrW-1:0] address;
  modport source (output valid, output address, input ready);
  modport sink (input valid, input address, output ready);
endinterface

interface cugw_out_if;
  logic valid;
  logic ready;
  logic [cugw_pkg::OrbW-1:0] orbital;
  logic last;
  logic bad_address;
  modport source (output valid, output orbital, output last, output bad_address, input ready);
  modport sink (input valid, input orbital, input last, input bad_address, output ready);
endinterface

interface cugw_cfg_if;
  logic valid;
  logic ready;
  logic [0:0] index;
  logic [cugw_pkg::CntW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/cugw_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// one buffer cell of the shift chain; shifts toward lower index
module cugw_cell (
  input  wire                       clk_i,
  input  wire                       load_i,
  input  wire                       shift_i,
  input  wire [cugw_pkg::OrbW-1:0]  load_val_i,
  input  wire [cugw_pkg::OrbW-1:0]  nbr_i,
  output logic [cugw_pkg::OrbW-1:0] val_o
);
  logic [cugw_pkg::OrbW-1:0] val_q;
  always_ff @(posedge clk_i) begin
    if (load_i) val_q <= load_val_i;
    else if (shift_i) val_q <= nbr_i;
  end
  assign val_o = val_q;
endmodule

// one binomial weight cell; lo is the lower neighbour, hi the upper one
module cugw_wcell (
  input  wire                       clk_i,
  input  wire [cugw_pkg::WopW-1:0]  op_i,
  input  wire [cugw_pkg::BinW-1:0]  seed_i,
  input  wire [cugw_pkg::BinW-1:0]  lo_i,
  input  wire [cugw_pkg::BinW-1:0]  hi_i,
  output logic [cugw_pkg::BinW-1:0] val_o
);
  logic [cugw_pkg::BinW-1:0] val_q, val_d;
  always_comb begin
    val_d = val_q;
    unique case (cugw_pkg::wop_e'(op_i))
      cugw_pkg::WHold: val_d = val_q;
      cugw_pkg::WSeed: val_d = seed_i;
      cugw_pkg::WUp:   val_d = lo_i;
      cugw_pkg::WDown: val_d = hi_i;
      cugw_pkg::WAdd:  val_d = val_q + lo_i;
      cugw_pkg::WSub:  val_d = val_q - hi_i;
      default:         val_d = val_q;
    endcase
  end
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end
  assign val_o = val_q;
endmodule
`default_nettype wire

### rtl/core/combination_unrank_graph_walk.sv
`timescale 1ns / 1ps
`default_nettype none
// Decodes a string address into its occupied orbitals, emitted ascending, one per request,
// the last marked. No binomial table is stored: a row chain of cells steps Pascal's triangle
// one row per cycle while a column chain collects C(j, num_electrons); during the walk each
// column cell either takes its upper neighbour (vertical arc) or subtracts it (diagonal arc),
// so the weight of the current vertex always sits in the bottom cell. An accepted address
// passes through the setup rows, a range check, the walk and the emit phase, then goes back
// to idle. An unusable shape gives its single flagged result directly from idle without
// setup, an out-of-range address gives one after the range check. Result stalls hold the
// emit phase; requests and register writes are taken only when idle with no result pending.
module combination_unrank_graph_walk (
  input wire clk_i,
  input wire rst_ni,
  cugw_in_if.sink   in_i,
  cugw_out_if.source out_o,
  cugw_cfg_if.sink  cfg_i
);
  localparam int unsigned N  = cugw_pkg::MaxRes;
  localparam int unsigned NC = cugw_pkg::MaxOrb;
  localparam int unsigned NR = cugw_pkg::MaxOrb + 1;
  localparam int unsigned KW = cugw_pkg::CntW + 1;
  localparam int unsigned RW = cugw_pkg::WgtW;

  cugw_pkg::state_e state_q, state_d;
  logic [cugw_pkg::CntW-1:0] norb_q, nel_q;
  logic [KW-1:0] k_q, k_d, m_q, m_d;
  logic [cugw_pkg::CntW-1:0] cnt_q, cnt_d;
  logic [RW-1:0] r_q, r_d;
  logic [cugw_pkg::BinW-1:0] w, feed;
  logic bad_q, bad_d, ov_q, ov_d;
  logic take, shape_bad;
  logic [N-1:0] load;
  logic shift;
  logic [cugw_pkg::OrbW-1:0] cval [N];
  logic [cugw_pkg::BinW-1:0] colv [NC];
  logic [cugw_pkg::BinW-1:0] rowv [NR];
  cugw_pkg::wop_e row_op, col_op;

  assign cfg_i.ready = (state_q == cugw_pkg::StIdle) && !ov_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      norb_q <= 6'd8;
      nel_q  <= 6'd4;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cugw_pkg::reg_idx_e'(cfg_i.index))
        cugw_pkg::RegOrbitals:  norb_q <= cfg_i.data;
        cugw_pkg::RegElectrons: nel_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // row chain entry for the electron count: C(row, num_electrons)
  assign feed = rowv[nel_q];
  assign w = colv[0];
  assign take = (k_q == m_q) || (r_q > {1'b0, w});
  assign shape_bad = (nel_q == '0) || (nel_q > norb_q)
    || ({1'b0, norb_q} > KW'(cugw_pkg::MaxOrb))
    || ({1'b0, nel_q} > KW'(cugw_pkg::MaxRes));

  assign in_i.ready = (state_q == cugw_pkg::StIdle) && !ov_q;
  assign out_o.valid = ov_q;
  assign out_o.orbital = bad_q ? '0 : cval[0];
  assign out_o.last = bad_q || (cnt_q == 6'd1);
  assign out_o.bad_address = bad_q;

  always_comb begin
    state_d = state_q; k_d = k_q; m_d = m_q; r_d = r_q;
    cnt_d = cnt_q; bad_d = bad_q; ov_d = ov_q;
    load = '0; shift = 1'b0;
    row_op = cugw_pkg::WHold; col_op = cugw_pkg::WHold;
    if (ov_q && out_o.ready) ov_d = 1'b0;
    unique case (state_q)
      cugw_pkg::StIdle: begin
        if (in_i.valid && in_i.ready) begin
          k_d = {1'b0, norb_q}; m_d = {1'b0, nel_q};
          r_d = {1'b0, in_i.address} + RW'(1);
          cnt_d = nel_q;
          bad_d = shape_bad;
          row_op = cugw_pkg::WSeed;
          if (shape_bad) ov_d = 1'b1;
          else state_d = cugw_pkg::StSetup;
        end
      end
      cugw_pkg::StSetup: begin
        // one Pascal row per cycle, its entry shifted into the column
        row_op = cugw_pkg::WAdd;
        col_op = cugw_pkg::WUp;
        k_d = k_q - KW'(1);
        if (k_q == KW'(1)) state_d = cugw_pkg::StCheck;
      end
      cugw_pkg::StCheck: begin
        k_d = {1'b0, norb_q};
        if (r_q > {1'b0, feed}) begin
          bad_d = 1'b1; ov_d = 1'b1; state_d = cugw_pkg::StIdle;
        end else begin
          state_d = cugw_pkg::StWalk;
        end
      end
      cugw_pkg::StWalk: begin
        if (m_q == '0 || k_q == '0) begin
          state_d = cugw_pkg::StEmit; ov_d = 1'b1;
        end else begin
          if (take) begin
            r_d = r_q - {1'b0, w}; m_d = m_q - KW'(1);
            load[m_d[4:0]] = 1'b1;
            col_op = cugw_pkg::WSub;
          end else begin
            col_op = cugw_pkg::WDown;
          end
          k_d = k_q - KW'(1);
        end
      end
      cugw_pkg::StEmit: begin
        if (ov_q && out_o.ready) begin
          shift = 1'b1;
          cnt_d = cnt_q - 6'd1;
          if (cnt_q == 6'd1) state_d = cugw_pkg::StIdle;
          else ov_d = 1'b1;
        end
      end
      default: state_d = cugw_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cugw_pkg::StIdle;
      ov_q <= 1'b0;
      bad_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      state_q <= state_d; ov_q <= ov_d; bad_q <= bad_d; cnt_q <= cnt_d;
    end
  end
  always_ff @(posedge clk_i) begin
    k_q <= k_d; m_q <= m_d; r_q <= r_d;
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    logic [cugw_pkg::OrbW-1:0] nbr;
    if (g == N - 1) begin : g_end
      assign nbr = cval[g];
    end else begin : g_mid
      assign nbr = cval[g + 1];
    end
    cugw_cell u_cell (
      .clk_i(clk_i), .load_i(load[g]), .shift_i(shift),
      .load_val_i(k_q[4:0] - 5'd1), .nbr_i(nbr), .val_o(cval[g])
    );
  end

  // row cell m holds C(row, m)
  for (genvar g = 0; g < NR; g++) begin : g_row
    logic [cugw_pkg::BinW-1:0] lo;
    if (g == 0) begin : g_first
      assign lo = '0;
    end else begin : g_next
      assign lo = rowv[g - 1];
    end
    cugw_wcell u_wcell (
      .clk_i(clk_i), .op_i(row_op),
      .seed_i((g == 0) ? cugw_pkg::BinW'(1) : cugw_pkg::BinW'(0)),
      .lo_i(lo), .hi_i('0), .val_o(rowv[g])
    );
  end

  // column cell j holds C(k-1-j, m) for the current vertex
  for (genvar g = 0; g < NC; g++) begin : g_col
    logic [cugw_pkg::BinW-1:0] lo, hi;
    if (g == 0) begin : g_first
      assign lo = feed;
    end else begin : g_next
      assign lo = colv[g - 1];
    end
    if (g == NC - 1) begin : g_top
      assign hi = '0;
    end else begin : g_below
      assign hi = colv[g + 1];
    end
    cugw_wcell u_wcell (
      .clk_i(clk_i), .op_i(col_op), .seed_i('0),
      .lo_i(lo), .hi_i(hi), .val_o(colv[g])
    );
  end

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != cugw_pkg::StIdle |-> !in_i.ready) else $error("accept while busy");
  a_bad_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.bad_address |-> out_o.last) else $error("bad not last");
  a_walk_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cugw_pkg::StWalk |-> !ov_q) else $error("output during walk");
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_i.valid && cfg_i.ready |-> state_q == cugw_pkg::StIdle)
    else $error("register write while busy");
`endif
endmodule
`default_nettype wire
